// File: sv/fsne_pkg.sv
// Package for the format string number emitter.
// Holds character codes, field widths, sequencer state type, converter status type, hex digit lookup.
// No dependencies.
package fsne_pkg;

   // Character codes
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_X       = 8'h78;
   localparam logic [7:0] CH_D       = 8'h64;
   localparam logic [7:0] CH_P       = 8'h70;
   localparam logic [7:0] CH_C       = 8'h63;

   // Field widths
   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned ARG_W    = 32;
   localparam int unsigned DIGITS   = 10;
   localparam int unsigned DIGBUF_W = 4 * DIGITS;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRE,
      ST_CONV,
      ST_SKIP,
      ST_DIGIT,
      ST_ONE
   } fsne_state_type;

   // Status of the binary-to-BCD unit
   typedef struct packed {
      logic busy;
      logic done;
   } fsne_conv_stat_type;

   // Nibble to lowercase hex character
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] res;
      if (nib < 4'd10) begin
         res = CH_ZERO + {4'd0, nib};
      end else begin
         res = 8'h57 + {4'd0, nib};
      end
      return res;
   endfunction

endpackage

// File: sv/fsne_bcd_conv.sv
// Iterative binary-to-BCD converter (shift and add three), one bit per cycle.
// Depends on fsne_pkg.
module fsne_bcd_conv (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [fsne_pkg::ARG_W-1:0]      value,
   output fsne_pkg::fsne_conv_stat_type    stat,
   output logic [fsne_pkg::DIGBUF_W-1:0]   bcd
);
   import fsne_pkg::*;

   localparam int unsigned CNT_W = $clog2(ARG_W);

   logic [ARG_W-1:0]    bin_ff;
   logic [DIGBUF_W-1:0] bcd_ff;
   logic [DIGBUF_W-1:0] adj;
   logic [CNT_W-1:0]    cnt_ff;
   logic                busy_ff;
   logic                done_ff;

   // Add three to every BCD digit of five or more
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // Control: busy for one pass over the word, done held until next start
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ARG_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Datapath: while busy, shift one binary bit into the BCD word each cycle
   always_ff @(posedge clock) begin
      if (start) begin
         bin_ff <= value;
         bcd_ff <= '0;
      end else if (busy_ff) begin
         bin_ff <= {bin_ff[ARG_W-2:0], 1'b0};
         bcd_ff <= {adj[DIGBUF_W-2:0], bin_ff[ARG_W-1]};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign bcd       = bcd_ff;

   // Busy and done never overlap
   a_busy_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("converter busy and done together");

   // Done follows the last shift step
   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == CNT_W'(ARG_W - 1)) |=> done_ff)
      else $error("converter did not finish after last step");

endmodule

// File: sv/format_string_number_emitter_top.sv
// Top level of the format string number emitter: handshakes, sequencer, output word.
// Depends on fsne_pkg and fsne_bcd_conv.
//
// Usage:
// The req channel takes one format byte with a 32-bit argument per word. The rsp
// channel returns the emitted characters, one per word, tlast on the final character
// caused by each request. A lone '%' produces no response word; it only arms the
// directive flag.
// An ordinary character passes through the ONE state into the output register after
// acceptance; a lone '%' leaves the sequencer idle. %x walks a ten-nibble digit
// buffer: it skips leading zero nibbles but keeps the last, then emits one character
// per nibble; %p first adds "0x". %d runs the shift-add-3 unit over the magnitude
// (a '-' leaves meanwhile), then drops leading zeros and emits digits the same way.
// req_tready is high only while the sequencer is idle, so a new request waits until
// the sequencer has finished the last one.
// A stalled receiver holds the output register; the sequencer waits with it and
// loses nothing. Synchronous reset clears the sequencer, the directive flag, the
// converter control and the output valid.
module format_string_number_emitter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] format_char, [39:8] argument_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_char
   output logic        rsp_tlast    // run_last
);
   import fsne_pkg::*;

   localparam int unsigned CNT_W = $clog2(DIGITS + 1);

   fsne_state_type      state_ff, state_in;
   logic                pend_ff;
   logic [15:0]         pre_ff;
   logic [1:0]          pre_cnt_ff;
   logic                dec_ff;
   logic [DIGBUF_W-1:0] dig_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [7:0]          one_ff;
   logic                rsp_valid_ff;
   logic [7:0]          rsp_char_ff;
   logic                rsp_last_ff;

   logic [7:0]          in_char;
   logic [ARG_W-1:0]    in_arg;
   logic [ARG_W-1:0]    magnitude;
   logic                req_fire;
   logic                out_free;
   logic                emit;
   logic [7:0]          emit_char;
   logic                emit_last;
   logic                conv_start;
   fsne_conv_stat_type  conv_stat;
   logic [DIGBUF_W-1:0] conv_bcd;

   assign in_char   = req_tdata[7:0];
   assign in_arg    = req_tdata[39:8];
   assign magnitude = in_arg[ARG_W-1] ? (~in_arg + 1'b1) : in_arg;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   fsne_bcd_conv u_conv (
      .clock (clock),
      .reset (reset),
      .start (conv_start),
      .value (magnitude),
      .stat  (conv_stat),
      .bcd   (conv_bcd)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (in_char == CH_PERCENT) begin
                  state_in = pend_ff ? ST_ONE : ST_IDLE;
               end else if (!pend_ff) begin
                  state_in = ST_ONE;
               end else if (in_char == CH_D) begin
                  state_in = in_arg[ARG_W-1] ? ST_PRE : ST_CONV;
               end else if (in_char == CH_X) begin
                  state_in = ST_SKIP;
               end else if (in_char == CH_P) begin
                  state_in = ST_PRE;
               end else begin
                  state_in = ST_ONE;
               end
            end
         end
         ST_PRE: begin
            if (out_free && pre_cnt_ff == 2'd1) begin
               state_in = dec_ff ? ST_CONV : ST_SKIP;
            end
         end
         ST_CONV: begin
            if (conv_stat.done) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (dig_ff[DIGBUF_W-1 -: 4] != 4'd0 || cnt_ff == CNT_W'(1)) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free && cnt_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_ONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      emit       = 1'b0;
      emit_char  = one_ff;
      emit_last  = 1'b0;
      conv_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            conv_start = req_fire && pend_ff && (in_char == CH_D);
         end
         ST_PRE: begin
            emit      = out_free;
            emit_char = pre_ff[7:0];
         end
         ST_DIGIT: begin
            emit      = out_free;
            emit_char = hex_char(dig_ff[DIGBUF_W-1 -: 4]);
            emit_last = (cnt_ff == CNT_W'(1));
         end
         ST_ONE: begin
            emit      = out_free;
            emit_last = 1'b1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            pend_ff <= (in_char == CH_PERCENT) ? !pend_ff : 1'b0;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_char_ff <= emit_char;
         rsp_last_ff <= emit_last;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cnt_ff <= CNT_W'(DIGITS);
               dig_ff <= {8'd0, in_arg};
               dec_ff <= (in_char == CH_D);
               if (in_char == CH_P) begin
                  pre_ff     <= {CH_X, CH_ZERO};
                  pre_cnt_ff <= 2'd2;
               end else begin
                  pre_ff     <= {8'd0, CH_MINUS};
                  pre_cnt_ff <= 2'd1;
               end
               if (pend_ff && in_char == CH_C) begin
                  one_ff <= in_arg[7:0];
               end else begin
                  one_ff <= in_char;
               end
            end
         end
         ST_PRE: begin
            if (out_free) begin
               pre_ff     <= {8'd0, pre_ff[15:8]};
               pre_cnt_ff <= pre_cnt_ff - 1'b1;
            end
         end
         ST_CONV: begin
            if (conv_stat.done) begin
               dig_ff <= conv_bcd;
            end
         end
         ST_SKIP: begin
            if (dig_ff[DIGBUF_W-1 -: 4] == 4'd0 && cnt_ff != CNT_W'(1)) begin
               dig_ff <= {dig_ff[DIGBUF_W-5:0], 4'd0};
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               dig_ff <= {dig_ff[DIGBUF_W-5:0], 4'd0};
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
         default: begin
            pre_cnt_ff <= pre_cnt_ff;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Directive flag is always clear once a request is being worked on
   a_pend_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !pend_ff)
      else $error("directive flag set while busy");

   // Converter is never running while a new request can be taken
   a_idle_conv_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !conv_stat.busy)
      else $error("converter busy in idle");

   // Digit counter stays in range while digits are handled
   a_digit_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT || state_ff == ST_SKIP) |->
      (cnt_ff != CNT_W'(0) && cnt_ff <= CNT_W'(DIGITS)))
      else $error("digit counter out of range");

   // An emitted word never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> ($stable(rsp_char_ff) && rsp_valid_ff))
      else $error("output word overwritten under stall");

endmodule

// File: test/format_string_number_emitter_top_tb.sv
// Self-checking testbench for the format string number emitter.
// Streams format bytes into the req channel and checks every rsp word against a local predictor.
// Depends on fsne_pkg and the format_string_number_emitter_top RTL.
`timescale 1ns / 100ps

module format_string_number_emitter_top_tb;
   import fsne_pkg::*;

   localparam int LONG_HOLD    = 400;   // receiver hold-off, in cycles
   localparam int HOLD_AT_WORD = 300;   // rsp word count that triggers the hold-off
   localparam int DRAIN_AT     = 250;   // first random item from here waits for an empty pipeline
   localparam int RANDOM_ITEMS = 440;
   localparam int SILENT_LIMIT = 4000;  // cycles with no word moving on either side
   localparam int TAIL_CYCLES  = 60;

   // One format byte as offered on the req channel
   typedef struct {
      logic [7:0]  fmt;
      logic [31:0] arg;
      bit          drain;   // hold back until every expected character has arrived
   } fmt_item_type;

   // One predicted rsp word
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } out_char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // [7:0] format_char, [39:8] argument_word
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [7:0] out_char
   logic        rsp_tlast;        // run_last

   fmt_item_type fmt_queue[$];
   out_char_type expected_chars[$];
   bit           percent_armed;
   int           items_total;
   int           items_sent;
   int           directives_seen;
   int           words_checked;
   int           mismatches;
   int           silent_cycles;

   // driver and monitor process state
   bit           offering;
   int           tx_gap;
   fmt_item_type next_fmt;
   int           rx_wait;
   out_char_type want;

   format_string_number_emitter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic queue_fmt(input logic [7:0] fmt, input logic [31:0] arg, input bit drain = 0);
      fmt_item_type it;
      it.fmt   = fmt;
      it.arg   = arg;
      it.drain = drain;
      fmt_queue.push_back(it);
   endtask

   // Characters a format byte gives, pushed onto the expected queue; tracks the '%' flag
   task automatic predict_emission(input logic [7:0] fmt, input logic [31:0] arg);
      string        glyphs;
      logic [7:0]   line[$];
      logic [7:0]   digits[$];
      logic [31:0]  mag;
      int           radix;
      bit           numeric;
      out_char_type oc;
      glyphs  = "0123456789abcdef";
      numeric = 1'b0;
      radix   = 16;
      mag     = arg;
      if (fmt == CH_PERCENT) begin
         if (percent_armed) line.push_back(CH_PERCENT);
         percent_armed = !percent_armed;
      end else if (percent_armed) begin
         percent_armed = 1'b0;
         directives_seen++;
         case (fmt)
            CH_D: begin
               radix   = 10;
               numeric = 1'b1;
               if (arg[31]) begin
                  line.push_back(CH_MINUS);
                  mag = ~arg + 32'd1;
               end
            end
            CH_X: numeric = 1'b1;
            CH_P: begin
               numeric = 1'b1;
               line.push_back(CH_ZERO);
               line.push_back(CH_X);
            end
            CH_C: line.push_back(arg[7:0]);
            default: line.push_back(fmt);
         endcase
      end else begin
         line.push_back(fmt);
      end
      // most significant digit first, at least one digit
      if (numeric) begin
         do begin
            digits.push_front(glyphs[mag % radix]);
            mag = mag / radix;
         end while (mag != 0);
         foreach (digits[i]) line.push_back(digits[i]);
      end
      foreach (line[i]) begin
         oc.ch   = line[i];
         oc.last = (i == line.size() - 1);
         expected_chars.push_back(oc);
      end
   endtask

   // Driver: offers queued format bytes with random gaps, predicts on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         offering = 1'b0;
         tx_gap   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_emission(req_tdata[7:0], req_tdata[39:8]);
            items_sent++;
            offering = 1'b0;
            tx_gap   = ((items_sent / 48) % 3 == 1) ? 0 : $urandom_range(0, 8);
         end
         if (!offering) begin
            if (tx_gap > 0) begin
               tx_gap--;
            end else if (fmt_queue.size() != 0 &&
                         !(fmt_queue[0].drain && expected_chars.size() != 0)) begin
               next_fmt = fmt_queue.pop_front();
               req_tdata <= {next_fmt.arg, next_fmt.fmt};
               offering = 1'b1;
            end
         end
         req_tvalid <= offering;
      end
   end

   // Monitor: random back-pressure, one long hold-off, checks each word in order
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected word char=%h last=%b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_tdata !== want.ch)
                  report_mismatch($sformatf("word %0d char %h, expected %h",
                                            words_checked, rsp_tdata, want.ch));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("word %0d last %b, expected %b",
                                            words_checked, rsp_tlast, want.last));
            end
            words_checked++;
            if (words_checked == HOLD_AT_WORD) rx_wait = LONG_HOLD;
            else if ((words_checked / 64) % 3 == 2) rx_wait = 0;
            else rx_wait = $urandom_range(0, 8);
         end else if (rx_wait > 0) begin
            rx_wait--;
         end
         rsp_tready <= (rx_wait == 0);
      end
   end

   // Watchdog on words moving in either direction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         silent_cycles <= 0;
      end else if (silent_cycles >= SILENT_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", silent_cycles);
         $display("FAILED: results differ");
         $finish;
      end else begin
         silent_cycles <= silent_cycles + 1;
      end
   end

   // Stimulus, reset and end of run
   initial begin
      logic [7:0]  fmt;
      logic [31:0] arg;
      int          kind;
      bit          drain_now;
      bit          drain_queued;

      drain_queued = 1'b0;

      // directed: plain bytes, zero byte, flag handling, every directive at its extremes
      queue_fmt("A", 32'hFFFF_FFFF);
      queue_fmt(8'h00, 32'h0);
      queue_fmt(8'hFF, 32'h0);
      queue_fmt(CH_D, 32'h1234_5678);           // 'd' with no flag is plain text
      queue_fmt(CH_PERCENT, 32'h0);             // lone percent: nothing out
      queue_fmt(CH_PERCENT, 32'hFFFF_FFFF);     // doubled percent
      queue_fmt(CH_PERCENT, 32'h0); queue_fmt(CH_D, 32'h0);
      queue_fmt(CH_PERCENT, 32'h0); queue_fmt(CH_D, 32'h7FFF_FFFF);
      queue_fmt(CH_PERCENT, 32'h0); queue_fmt(CH_D, 32'h8000_0000);
      queue_fmt(CH_PERCENT, 32'h0); queue_fmt(CH_D, 32'hFFFF_FFFF);
      queue_fmt(CH_PERCENT, 32'h0); queue_fmt(CH_X, 32'h0);
      queue_fmt(CH_PERCENT, 32'h0); queue_fmt(CH_X, 32'hFFFF_FFFF);
      queue_fmt(CH_PERCENT, 32'h0); queue_fmt(CH_P, 32'h0);
      queue_fmt(CH_PERCENT, 32'h0); queue_fmt(CH_P, 32'hFFFF_FFFF);
      queue_fmt(CH_PERCENT, 32'h0); queue_fmt(CH_C, 32'hFFFF_FF41);
      queue_fmt(CH_PERCENT, 32'h0); queue_fmt(CH_C, 32'hFFFF_FF00);
      queue_fmt(CH_PERCENT, 32'h0); queue_fmt("s", 32'h0);      // string not supported
      queue_fmt(CH_PERCENT, 32'h0); queue_fmt(8'h00, 32'h5);    // unknown directive

      // random: mostly well-formed directives, some plain text and noise
      for (int n = 0; n < RANDOM_ITEMS; ) begin
         kind = $urandom_range(0, 9);
         arg  = $urandom;
         drain_now    = !drain_queued && (n >= DRAIN_AT);
         drain_queued = drain_queued || drain_now;
         case ($urandom_range(0, 3))
            0: arg = arg >> $urandom_range(0, 31);
            1: arg = -(arg >> $urandom_range(1, 31));
            2: arg = $urandom_range(0, 9);
            default: ;
         endcase
         if (kind <= 5) begin
            case ($urandom_range(0, 7))
               0, 1: fmt = CH_D;
               2:    fmt = CH_X;
               3:    fmt = CH_P;
               4:    fmt = CH_C;
               5:    fmt = CH_PERCENT;
               6:    fmt = "s";
               default: fmt = 8'($urandom_range(0, 255));
            endcase
            queue_fmt(CH_PERCENT, $urandom, drain_now);
            queue_fmt(fmt, arg);
            n += 2;
         end else if (kind <= 8) begin
            queue_fmt(8'($urandom_range(0, 255)), arg, drain_now);
            n++;
         end else begin
            queue_fmt(CH_PERCENT, arg, drain_now);
            n++;
         end
      end
      items_total = fmt_queue.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (items_sent != items_total) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d format bytes, %0d of them closing a directive, through the block.",
               items_sent, directives_seen);
      $display("Checked %0d emitted characters under random gaps and a %0d-cycle hold-off.",
               words_checked, LONG_HOLD);
      if (mismatches == 0 && expected_chars.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// File: format_string_number_emitter_top.f
sv/fsne_pkg.sv
sv/fsne_bcd_conv.sv
sv/format_string_number_emitter_top.sv
test/format_string_number_emitter_top_tb.sv
